FILE: rtl/multi_writer_frame_ring_macros.svh
// ----------------------------------------------------------------------------
// Frame ring assertion macros
// Concurrent checks on clk with rst_n as the disable condition. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_WRITER_FRAME_RING_MACROS_SVH
`define MULTI_WRITER_FRAME_RING_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MWFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame ring check failed");

// Consequent must hold in the cycle after the antecedent.
`define MWFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame ring check failed");

`else

`define MWFR_ASSERT_IMPL(label, ante, cons)
`define MWFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/mwfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame ring package
// Item types, command and status codes, register indexes and helpers shared
// by the frame ring modules.
// ----------------------------------------------------------------------------
package mwfr_pkg;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 7;
    localparam int FRAMES_READY_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_RING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WRITERS = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [2:0] writer;
        logic [5:0] byte_pos;
        logic [7:0] data_in;
        logic       end_of_frame;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [7:0]                data_out;
        logic                      last;
        logic                      writer_full;
        logic [FRAMES_READY_W-1:0] frames_ready;
    } rsp_t;

    // Compare results of the slot distance unit.
    typedef struct packed {
        logic at_full;
        logic below_min;
    } dist_flags_t;

    function automatic int clamp_cfg(int value, int lo, int hi);
        int result;
        result = value;
        if (value < lo) begin
            result = lo;
        end else if (value > hi) begin
            result = hi;
        end
        return result;
    endfunction

endpackage

FILE: rtl/mwfr_dist.sv
// ----------------------------------------------------------------------------
// Frame ring slot distance unit
// Shared modular subtract: slots between a writer pointer and the read
// pointer, compared against the full mark and a running minimum.
// ----------------------------------------------------------------------------
module mwfr_dist
    import mwfr_pkg::*;
#(
    parameter int SW = 4
) (
    input  logic [SW-1:0] wslot,
    input  logic [SW-1:0] rslot,
    input  logic [SW-1:0] fir,
    input  logic [SW:0]   cur_min,
    output logic [SW-1:0] gap,
    output dist_flags_t   flags
);

    logic [SW:0] slots;
    logic [SW:0] diff;

    always_comb
    begin
        slots = {1'b0, fir} + {{SW{1'b0}}, 1'b1};
        if (wslot >= rslot)
        begin
            diff = {1'b0, wslot} - {1'b0, rslot};
        end
        else
        begin
            // Pointer wrapped past the end of the ring.
            diff = ({1'b0, wslot} + slots) - {1'b0, rslot};
        end
        gap             = diff[SW-1:0];
        flags.at_full   = (diff[SW-1:0] == fir);
        flags.below_min = ({1'b0, diff[SW-1:0]} < cur_min);
    end

endmodule

FILE: rtl/mwfr_store.sv
// ----------------------------------------------------------------------------
// Frame ring byte store
// Single write port, single registered read port. Contents are undefined
// until written.
// ----------------------------------------------------------------------------
module mwfr_store
    import mwfr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/multi_writer_frame_ring.sv
// ----------------------------------------------------------------------------
// Multi-writer transmit frame ring
// Write item: checked, then answered; when end_of_frame advances the pointer,
//   the active writers are recounted first (the shared distance unit visits
//   one writer a cycle). Read item: a store read per byte, each answered
//   once the response register is free. Empty read: answered after the check.
// Reset is asynchronous: pointers and count clear, the byte store is not cleared.
// ----------------------------------------------------------------------------
`include "multi_writer_frame_ring_macros.svh"

module multi_writer_frame_ring
    import mwfr_pkg::*;
#(
    parameter int MAX_WRITERS     = 8,
    parameter int RING_SLOTS      = 16,
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW      = $clog2(RING_SLOTS);
    localparam int WW      = (MAX_WRITERS > 1) ? $clog2(MAX_WRITERS) : 1;
    localparam int ACW     = $clog2(MAX_WRITERS + 1);
    localparam int FBW     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int DEPTH   = RING_SLOTS * MAX_FRAME_BYTES;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FIR_RST = (RING_SLOTS - 1 < 15) ? RING_SLOTS - 1 : 15;
    localparam int FB_RST  = (MAX_FRAME_BYTES < 64) ? MAX_FRAME_BYTES : 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RECOUNT,
        S_FINAL,
        S_RESULT,
        S_RD_ISSUE,
        S_RD_WAIT
    } state_t;

    state_t               state_reg, state_next;
    req_t                 item_reg, item_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 cfg_recount_reg, cfg_recount_next;
    logic [WW-1:0]        wcnt_reg, wcnt_next;
    logic [SW:0]          min_reg, min_next;
    logic                 full_reg, full_next;
    logic [1:0]           status_reg, status_next;
    logic [SW-1:0]        base_slot_reg, base_slot_next;
    logic [FBW-1:0]       byte_idx_reg, byte_idx_next;
    logic [FBW-1:0]       fb_reg, fb_next;
    logic [SW-1:0]        fir_reg, fir_next;
    logic [ACW-1:0]       act_reg, act_next;
    logic [SW-1:0]        writer_slot_reg [MAX_WRITERS];
    logic [SW-1:0]        writer_slot_next [MAX_WRITERS];
    logic [SW-1:0]        read_slot_reg, read_slot_next;
    logic [SW-1:0]        ready_cnt_reg, ready_cnt_next;

    logic [WW-1:0]        item_wi;
    logic [WW-1:0]        sel_wi;
    logic                 wvalid;
    logic                 rsp_free;
    logic [SW-1:0]        unit_wslot;
    logic [SW-1:0]        unit_dist;
    dist_flags_t          unit_flags;
    logic [SW-1:0]        min_new;
    logic                 last_byte;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [7:0]           mem_rdata;

    assign item_wi    = WW'(item_reg.writer);
    assign wvalid     = (32'(item_reg.writer) < 32'(MAX_WRITERS));
    assign sel_wi     = (state_reg == S_RECOUNT) ? wcnt_reg : item_wi;
    assign unit_wslot = writer_slot_reg[sel_wi];
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign min_new    = unit_flags.below_min ? unit_dist : min_reg[SW-1:0];
    assign last_byte  = ((32'(byte_idx_reg) + 32'd1) == 32'(fb_reg));

    assign mem_waddr = AW'(32'(writer_slot_reg[item_wi]) * MAX_FRAME_BYTES
                           + 32'(item_reg.byte_pos));
    assign mem_raddr = AW'(32'(base_slot_reg) * MAX_FRAME_BYTES + 32'(byte_idx_reg));

    mwfr_dist #(
        .SW (SW)
    ) u_dist (
        .wslot   (unit_wslot),
        .rslot   (read_slot_reg),
        .fir     (fir_reg),
        .cur_min (min_reg),
        .gap     (unit_dist),
        .flags   (unit_flags)
    );

    mwfr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (item_reg.data_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        cfg_recount_next = cfg_recount_reg;
        wcnt_next        = wcnt_reg;
        min_next         = min_reg;
        full_next        = full_reg;
        status_next      = status_reg;
        base_slot_next   = base_slot_reg;
        byte_idx_next    = byte_idx_reg;
        fb_next          = fb_reg;
        fir_next         = fir_reg;
        act_next         = act_reg;
        writer_slot_next = writer_slot_reg;
        read_slot_next   = read_slot_reg;
        ready_cnt_next   = ready_cnt_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                status_next = STATUS_OK;
                if (item_reg.cmd == CMD_WRITE)
                begin
                    if (!wvalid)
                    begin
                        full_next  = 1'b0;
                        state_next = S_RESULT;
                    end
                    else if (unit_flags.at_full)
                    begin
                        status_next = STATUS_FULL;
                        full_next   = 1'b1;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        mem_we = (32'(item_reg.byte_pos) < 32'(fb_reg));
                        if (item_reg.end_of_frame)
                        begin
                            writer_slot_next[item_wi] = (unit_wslot == fir_reg) ? '0
                                : unit_wslot + SW'(1);
                            wcnt_next        = '0;
                            min_next         = {1'b0, fir_reg} + {{SW{1'b0}}, 1'b1};
                            cfg_recount_next = 1'b0;
                            state_next       = S_RECOUNT;
                        end
                        else
                        begin
                            full_next  = 1'b0;
                            state_next = S_RESULT;
                        end
                    end
                end
                else if (ready_cnt_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                    full_next   = wvalid && unit_flags.at_full;
                    state_next  = S_RESULT;
                end
                else
                begin
                    base_slot_next = read_slot_reg;
                    read_slot_next = (read_slot_reg == fir_reg) ? '0
                        : read_slot_reg + SW'(1);
                    ready_cnt_next = ready_cnt_reg - SW'(1);
                    state_next     = S_FINAL;
                end
            end

            S_RECOUNT:
            begin
                // One writer per cycle through the shared distance unit.
                min_next = {1'b0, min_new};
                if ((32'(wcnt_reg) + 32'd1) >= 32'(act_reg))
                begin
                    ready_cnt_next = min_new;
                    state_next     = cfg_recount_reg ? S_IDLE : S_FINAL;
                end
                else
                begin
                    wcnt_next = wcnt_reg + WW'(1);
                end
            end

            S_FINAL:
            begin
                full_next = wvalid && unit_flags.at_full;
                if (item_reg.cmd == CMD_WRITE)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    byte_idx_next = '0;
                    state_next    = S_RD_ISSUE;
                end
            end

            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.data_out     = '0;
                    rsp_next.last         = 1'b1;
                    rsp_next.writer_full  = full_reg;
                    rsp_next.frames_ready = FRAMES_READY_W'(ready_cnt_reg);
                    state_next            = S_IDLE;
                end
            end

            S_RD_ISSUE:
            begin
                mem_re     = 1'b1;
                state_next = S_RD_WAIT;
            end

            S_RD_WAIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = STATUS_OK;
                    rsp_next.data_out     = mem_rdata;
                    rsp_next.last         = last_byte;
                    rsp_next.writer_full  = full_reg;
                    rsp_next.frames_ready = FRAMES_READY_W'(ready_cnt_reg);
                    if (last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + FBW'(1);
                        state_next    = S_RD_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Geometry writes flush the ring; a writer count write recounts it.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_BYTES:
                begin
                    fb_next = FBW'(clamp_cfg(32'(cfg_data), 1, MAX_FRAME_BYTES));
                    writer_slot_next = '{default: '0};
                    read_slot_next   = '0;
                    ready_cnt_next   = '0;
                    state_next       = S_IDLE;
                end
                CFG_FRAMES_IN_RING:
                begin
                    fir_next = SW'(clamp_cfg(32'(cfg_data), 1, RING_SLOTS - 1));
                    writer_slot_next = '{default: '0};
                    read_slot_next   = '0;
                    ready_cnt_next   = '0;
                    state_next       = S_IDLE;
                end
                CFG_ACTIVE_WRITERS:
                begin
                    act_next = ACW'(clamp_cfg(32'(cfg_data), 1, MAX_WRITERS));
                    wcnt_next        = '0;
                    min_next         = {1'b0, fir_reg} + {{SW{1'b0}}, 1'b1};
                    cfg_recount_next = 1'b1;
                    state_next       = S_RECOUNT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            cfg_recount_reg <= 1'b0;
            wcnt_reg        <= '0;
            min_reg         <= '0;
            full_reg        <= 1'b0;
            status_reg      <= STATUS_OK;
            base_slot_reg   <= '0;
            byte_idx_reg    <= '0;
            fb_reg          <= FBW'(FB_RST);
            fir_reg         <= SW'(FIR_RST);
            act_reg         <= ACW'(1);
            writer_slot_reg <= '{default: '0};
            read_slot_reg   <= '0;
            ready_cnt_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            rsp_reg         <= rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
            cfg_recount_reg <= cfg_recount_next;
            wcnt_reg        <= wcnt_next;
            min_reg         <= min_next;
            full_reg        <= full_next;
            status_reg      <= status_next;
            base_slot_reg   <= base_slot_next;
            byte_idx_reg    <= byte_idx_next;
            fb_reg          <= fb_next;
            fir_reg         <= fir_next;
            act_reg         <= act_next;
            writer_slot_reg <= writer_slot_next;
            read_slot_reg   <= read_slot_next;
            ready_cnt_reg   <= ready_cnt_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MWFR_ASSERT_IMPL(a_ready_cnt_bound, 1'b1, ready_cnt_reg <= fir_reg)
    `MWFR_ASSERT_IMPL(a_read_slot_bound, 1'b1, read_slot_reg <= fir_reg)
    `MWFR_ASSERT_NEXT(a_one_item_at_a_time, req_valid && req_ready && !cfg_we, !req_ready)
    `MWFR_ASSERT_IMPL(a_empty_single, rsp_valid && rsp.status == STATUS_EMPTY, rsp.last && rsp.data_out == 8'd0)

endmodule
